>>> rtl/dbd_pkg.sv
// Shared types and constants of the dual byte header packet deframer.
// Depends on nothing; every other file of the block but dbd_if imports it.
package dbd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   // Configuration registers as seen by the parser.
   typedef struct packed {
      logic [7:0] header_a;
      logic [7:0] header_b;
      logic [7:0] header_c;
      logic [7:0] header_d;
      logic [7:0] tail;
      logic [7:0] max_len;
   } cfg_type;

   // One parsed byte: zero to two ring writes followed by an optional close.
   typedef struct packed {
      logic [1:0] n_writes;
      logic [7:0] addr0;
      logic [7:0] addr1;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       close;
      logic [7:0] start;
      logic [7:0] length;
      logic [2:0] hid;
      logic [1:0] slot;
   } cmd_type;

endpackage

>>> rtl/dbd_if.sv
// Valid/ready channel interfaces for received bytes and for results.
// Does not import dbd_pkg; its field widths only match it by house consistency.
interface dbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] write_addr;
   logic [7:0] payload_byte;
   logic [7:0] packet_start;
   logic [7:0] packet_length;
   logic [2:0] header_id;
   logic [1:0] slot;
   logic       last;

   modport source (output valid, output kind, output write_addr, output payload_byte,
                   output packet_start, output packet_length, output header_id,
                   output slot, output last, input ready);
   modport sink (input valid, input kind, input write_addr, input payload_byte,
                 input packet_start, input packet_length, input header_id,
                 input slot, input last, output ready);
endinterface

>>> rtl/dual_byte_header_packet_deframer.sv
// Received bytes come in on req_ch one transaction at a time and are framed
// into packets: a doubled header byte opens a packet, payload bytes are
// reported as ring buffer writes, and a doubled tail byte (or reaching the
// maximum length) closes it with a descriptor of start, length, header id and
// slot. An accepted byte produces zero to three result transactions on rsp_ch,
// which leave one per cycle from a registered output while rsp_ch.ready is
// high. The parser and the result sequencer are parted by a two-entry
// command queue, so the parser keeps taking bytes while earlier results are
// still draining or stalled; req_ch only stalls when that queue is full.
// Configuration registers are written through the csr_ port and take effect
// on the next accepted byte.
// Depends on dbd_pkg, dbd_if, dbd_front, dbd_cmd_queue and dbd_back.
module dual_byte_header_packet_deframer #(
   parameter int BUFFER_DEPTH = 256,
   parameter int SLOT_COUNT   = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   dbd_req_if.sink                          req_ch,
   dbd_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_en,
   input  logic [dbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dbd_pkg::*;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN  = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [7:0] RST_HEADER_A = 8'hFF;
   localparam logic [7:0] RST_HEADER_B = 8'hEE;
   localparam logic [7:0] RST_HEADER_C = 8'hFD;
   localparam logic [7:0] RST_HEADER_D = 8'hCC;
   localparam logic [7:0] RST_TAIL     = 8'hDD;
   localparam logic [7:0] RST_MAX_LEN  = 8'd64;

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   // Writes to an index beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEADER_A: cfg_in.header_a = csr_wdata;
            CSR_HEADER_B: cfg_in.header_b = csr_wdata;
            CSR_HEADER_C: cfg_in.header_c = csr_wdata;
            CSR_HEADER_D: cfg_in.header_d = csr_wdata;
            CSR_TAIL:     cfg_in.tail     = csr_wdata;
            CSR_MAX_LEN:  cfg_in.max_len  = csr_wdata;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_a <= RST_HEADER_A;
         cfg_ff.header_b <= RST_HEADER_B;
         cfg_ff.header_c <= RST_HEADER_C;
         cfg_ff.header_d <= RST_HEADER_D;
         cfg_ff.tail     <= RST_TAIL;
         cfg_ff.max_len  <= RST_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The parser holds all framing state and resolves each byte completely
   // in the cycle it is accepted, including the overflow cases.
   dbd_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .SLOT_COUNT   (SLOT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   dbd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The sequencer expands each command into its writes and descriptor and
   // marks the final result of the byte with last.
   dbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

>>> rtl/dbd_front.sv
// Front end: accepts received bytes, runs the framing state machine and turns
// each byte that yields results into one command. Depends on dbd_pkg and dbd_req_if.
module dbd_front #(
   parameter int BUFFER_DEPTH = 256,
   parameter int SLOT_COUNT   = 4
) (
   input  logic             clock,
   input  logic             reset,
   dbd_req_if.sink          req,
   input  dbd_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             cmd_push,
   output dbd_pkg::cmd_type cmd
);
   import dbd_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int SW = $clog2(SLOT_COUNT);

   typedef enum logic [3:0] {
      ST_HDR1 = 4'b0001,
      ST_HDR2 = 4'b0010,
      ST_DATA = 4'b0100,
      ST_TAIL = 4'b1000
   } parse_state_type;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == AW'(BUFFER_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Ring distance from s up to a.
   function automatic logic [AW-1:0] ring_dist(input logic [AW-1:0] a,
                                                input logic [AW-1:0] s);
      logic [AW:0] d;
      d = {1'b0, a} - {1'b0, s};
      if (d[AW]) begin
         d = d + (AW+1)'(BUFFER_DEPTH);
      end
      return d[AW-1:0];
   endfunction

   parse_state_type state_ff, state_in;
   logic [2:0]      matched_ff, matched_in;
   logic [AW-1:0]   wp_ff, wp_in;
   logic [AW-1:0]   start_ff, start_in;
   logic [SW-1:0]   slot_ff, slot_in;

   logic            accept;
   logic [7:0]      b;
   logic [2:0]      hid_b;
   logic            is_tail;
   logic [AW-1:0]   wp_inc1, wp_inc2;
   logic [AW-1:0]   len0, len1, len2;
   logic            ovf1, ovf2;
   logic [SW-1:0]   slot_next;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign is_tail   = (b == cfg.tail);

   always_comb begin
      priority if (b == cfg.header_a) begin
         hid_b = 3'd1;
      end else if (b == cfg.header_b) begin
         hid_b = 3'd2;
      end else if (b == cfg.header_c) begin
         hid_b = 3'd3;
      end else if (b == cfg.header_d) begin
         hid_b = 3'd4;
      end else begin
         hid_b = 3'd0;
      end
   end

   assign wp_inc1   = ptr_inc(wp_ff);
   assign wp_inc2   = ptr_inc(wp_inc1);
   assign len0      = ring_dist(wp_ff, start_ff);
   assign len1      = ring_dist(wp_inc1, start_ff);
   assign len2      = ring_dist(wp_inc2, start_ff);
   assign ovf1      = (8'(len1) >= cfg.max_len);
   assign ovf2      = (8'(len2) >= cfg.max_len);
   assign slot_next = (slot_ff == SW'(SLOT_COUNT - 1)) ? '0 : slot_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      matched_in = matched_ff;
      wp_in      = wp_ff;
      start_in   = start_ff;
      slot_in    = slot_ff;

      cmd          = '0;
      cmd.addr0    = 8'(wp_ff);
      cmd.addr1    = 8'(wp_inc1);
      cmd.byte0    = b;
      cmd.byte1    = b;
      cmd.start    = 8'(start_ff);
      cmd.hid      = matched_ff;
      cmd.slot     = 2'(slot_ff);

      unique case (state_ff)
         ST_HDR1: begin
            state_in   = ST_HDR2;
            matched_in = hid_b;
         end
         ST_HDR2: begin
            if (matched_ff != 3'd0 && hid_b == matched_ff) begin
               state_in = ST_DATA;
               start_in = wp_ff;
            end else begin
               state_in   = ST_HDR1;
               matched_in = 3'd0;
            end
         end
         ST_DATA: begin
            if (is_tail) begin
               state_in = ST_TAIL;
            end else begin
               cmd.n_writes = 2'd1;
               wp_in        = wp_inc1;
               if (ovf1) begin
                  cmd.close  = 1'b1;
                  cmd.length = 8'(len1);
                  slot_in    = slot_next;
                  state_in   = ST_HDR1;
                  matched_in = 3'd0;
               end
            end
         end
         ST_TAIL: begin
            if (is_tail) begin
               cmd.close  = 1'b1;
               cmd.length = 8'(len0);
               slot_in    = slot_next;
               state_in   = ST_HDR1;
               matched_in = 3'd0;
            end else begin
               cmd.byte0 = cfg.tail;
               state_in  = ST_DATA;
               if (ovf1) begin
                  // The stored tail fills the packet; the byte restarts the header hunt.
                  cmd.n_writes = 2'd1;
                  wp_in        = wp_inc1;
                  cmd.close    = 1'b1;
                  cmd.length   = 8'(len1);
                  slot_in      = slot_next;
                  state_in     = ST_HDR2;
                  matched_in   = hid_b;
               end else begin
                  cmd.n_writes = 2'd2;
                  wp_in        = wp_inc2;
                  if (ovf2) begin
                     cmd.close  = 1'b1;
                     cmd.length = 8'(len2);
                     slot_in    = slot_next;
                     state_in   = ST_HDR1;
                     matched_in = 3'd0;
                  end
               end
            end
         end
         default: begin
            state_in   = ST_HDR1;
            matched_in = 3'd0;
         end
      endcase
   end

   assign cmd_push = accept && (cmd.n_writes != 2'd0 || cmd.close);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HDR1;
         matched_ff <= 3'd0;
         wp_ff      <= '0;
         start_ff   <= '0;
         slot_ff    <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         matched_ff <= matched_in;
         wp_ff      <= wp_in;
         start_ff   <= start_in;
         slot_ff    <= slot_in;
      end
   end

endmodule

>>> rtl/dbd_cmd_queue.sv
// Two-entry command queue between the parser and the result sequencer.
// Depends on dbd_pkg for the command type.
module dbd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dbd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output dbd_pkg::cmd_type head_cmd
);
   import dbd_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/dbd_back.sv
// Back end: steps through the queued command one result per cycle, held while
// rsp is stalled, into a registered result port. Depends on dbd_pkg and dbd_rsp_if.
module dbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  dbd_pkg::cmd_type head_cmd,
   output logic             pop,
   dbd_rsp_if.source        rsp
);
   import dbd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] start_ff, start_in;
   logic [7:0] length_ff, length_in;
   logic [2:0] hid_ff, hid_in;
   logic [1:0] slot_ff, slot_in;
   logic       last_ff, last_in;

   logic       load;
   logic [1:0] n_results;
   logic       is_write;

   assign load      = head_valid && (!out_valid_ff || rsp.ready);
   assign n_results = head_cmd.n_writes + {1'b0, head_cmd.close};
   assign is_write  = (idx_ff < head_cmd.n_writes);
   assign last_in   = (idx_ff == n_results - 2'd1);
   assign pop       = load && last_in;

   always_comb begin
      kind_in   = KIND_CLOSE;
      addr_in   = 8'd0;
      data_in   = 8'd0;
      start_in  = head_cmd.start;
      length_in = head_cmd.length;
      hid_in    = head_cmd.hid;
      slot_in   = head_cmd.slot;
      if (is_write) begin
         kind_in   = KIND_WRITE;
         addr_in   = (idx_ff == 2'd0) ? head_cmd.addr0 : head_cmd.addr1;
         data_in   = (idx_ff == 2'd0) ? head_cmd.byte0 : head_cmd.byte1;
         start_in  = 8'd0;
         length_in = 8'd0;
         hid_in    = 3'd0;
         slot_in   = 2'd0;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = last_in ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         addr_ff   <= addr_in;
         data_ff   <= data_in;
         start_ff  <= start_in;
         length_ff <= length_in;
         hid_ff    <= hid_in;
         slot_ff   <= slot_in;
         last_ff   <= last_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.write_addr    = addr_ff;
   assign rsp.payload_byte  = data_ff;
   assign rsp.packet_start  = start_ff;
   assign rsp.packet_length = length_ff;
   assign rsp.header_id     = hid_ff;
   assign rsp.slot          = slot_ff;
   assign rsp.last          = last_ff;

endmodule

>>> sim/dual_byte_header_packet_deframer_tb.sv
// Self-checking testbench for the dual byte header packet deframer.
// Depends on dbd_pkg, dbd_if and the dual_byte_header_packet_deframer RTL.
// A scoreboard class predicts every result transaction from the accepted bytes.
module dual_byte_header_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dbd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 150;
   localparam int RANDOM_ITEMS = 52;
   localparam int PHASES       = 5;

   // Register indexes, in the order of the register map.
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LEN  = 3'd5;

   typedef enum logic [1:0] {
      SEEK_FIRST,
      SEEK_SECOND,
      IN_PAYLOAD,
      TAIL_PENDING
   } parse_phase_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_THREE_ON_ONE_OFF
   } ready_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] write_addr;
      logic [7:0] payload_byte;
      logic [7:0] packet_start;
      logic [7:0] packet_length;
      logic [2:0] header_id;
      logic [1:0] slot;
      logic       last;
   } frame_result_type;

   // Predicts the deframer and holds the results still owed by the block.
   class deframe_scoreboard;
      cfg_type          cfg;
      parse_phase_type  phase;
      logic [2:0]       open_hid;
      logic [7:0]       wr_ptr;
      logic [7:0]       pkt_start;
      logic [1:0]       slot_ptr;
      frame_result_type owed_q[$];
      frame_result_type step_q[$];
      int               errors;

      function new();
         cfg.header_a = 8'hFF;
         cfg.header_b = 8'hEE;
         cfg.header_c = 8'hFD;
         cfg.header_d = 8'hCC;
         cfg.tail     = 8'hDD;
         cfg.max_len  = 8'd64;
         phase     = SEEK_FIRST;
         open_hid  = '0;
         wr_ptr    = '0;
         pkt_start = '0;
         slot_ptr  = '0;
         errors    = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
         case (idx)
            REG_HEADER_A: cfg.header_a = value;
            REG_HEADER_B: cfg.header_b = value;
            REG_HEADER_C: cfg.header_c = value;
            REG_HEADER_D: cfg.header_d = value;
            REG_TAIL:     cfg.tail     = value;
            REG_MAX_LEN:  cfg.max_len  = value;
            default: ;
         endcase
      endfunction

      // The lowest letter wins when header registers hold the same byte.
      function logic [2:0] header_match(logic [7:0] b);
         if (b == cfg.header_a) return 3'd1;
         if (b == cfg.header_b) return 3'd2;
         if (b == cfg.header_c) return 3'd3;
         if (b == cfg.header_d) return 3'd4;
         return 3'd0;
      endfunction

      // The 256-entry ring wraps on its own in 8-bit arithmetic.
      function logic [7:0] fill_level();
         return wr_ptr - pkt_start;
      endfunction

      function bit store_payload(logic [7:0] b);
         frame_result_type r;
         r = '0;
         r.kind = KIND_WRITE;
         r.write_addr = wr_ptr;
         r.payload_byte = b;
         step_q.push_back(r);
         wr_ptr = wr_ptr + 8'd1;
         return fill_level() >= cfg.max_len;
      endfunction

      function void seal_packet();
         frame_result_type r;
         r = '0;
         r.kind = KIND_CLOSE;
         r.packet_start = pkt_start;
         r.packet_length = fill_level();
         r.header_id = open_hid;
         r.slot = slot_ptr;
         step_q.push_back(r);
         slot_ptr = slot_ptr + 2'd1;
         phase = SEEK_FIRST;
         open_hid = '0;
      endfunction

      function void note_byte(logic [7:0] b);
         frame_result_type r;
         case (phase)
            SEEK_FIRST: begin
               phase = SEEK_SECOND;
               open_hid = header_match(b);
            end
            SEEK_SECOND: begin
               if (open_hid != 3'd0 && header_match(b) == open_hid) begin
                  phase = IN_PAYLOAD;
                  pkt_start = wr_ptr;
               end else begin
                  open_hid = '0;
                  phase = SEEK_FIRST;
               end
            end
            IN_PAYLOAD: begin
               if (b == cfg.tail) phase = TAIL_PENDING;
               else if (store_payload(b)) seal_packet();
            end
            default: begin
               if (b == cfg.tail) begin
                  seal_packet();
               end else begin
                  phase = IN_PAYLOAD;
                  // An overflow on the held tail byte hands the current byte
                  // back to the header search instead of storing it.
                  if (store_payload(cfg.tail)) begin
                     seal_packet();
                     phase = SEEK_SECOND;
                     open_hid = header_match(b);
                  end else if (store_payload(b)) begin
                     seal_packet();
                  end
               end
            end
         endcase
         while (step_q.size() > 0) begin
            r = step_q.pop_front();
            r.last = (step_q.size() == 0);
            owed_q.push_back(r);
         end
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (owed_q.size() == 0) begin
            $error("result with nothing owed: kind %0d addr %0d byte %0d",
                   got.kind, got.write_addr, got.payload_byte);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("write_addr", want.write_addr, got.write_addr);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("packet_start", want.packet_start, got.packet_start);
         compare_field("packet_length", want.packet_length, got.packet_length);
         compare_field("header_id", want.header_id, got.header_id);
         compare_field("slot", want.slot, got.slot);
         compare_field("last", want.last, got.last);
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dbd_req_if req_ch ();
   dbd_rsp_if rsp_ch ();

   deframe_scoreboard sb = new();

   // Sender burst bookkeeping and the long receiver hold handshake.
   int burst_left;
   int hold_requests;
   int cycle_count;
   int items_sent;

   dual_byte_header_packet_deframer uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dual_byte_header_packet_deframer_tb: errors");
      $finish;
   end

   // The receiver stalls on a pattern in a mode that is redrawn at random. A long
   // hold, once asked for, is counted down here while the sender keeps offering
   // bytes so the command queue fills and req_ch stalls.
   initial begin
      int             hold_served;
      int             hold_left;
      int             mode_left;
      int             beat;
      ready_mode_type mode;
      hold_served = 0;
      hold_left = 0;
      mode_left = 0;
      beat = 0;
      mode = READY_ALWAYS;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         beat++;
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_ch.ready <= 1'b1;
               READY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               default:      rsp_ch.ready <= (beat % 4 != 3);
            endcase
         end
      end
   end

   // Every result transaction is checked against the oldest owed result.
   always @(posedge clock) begin : result_monitor
      frame_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind = rsp_ch.kind;
         got.write_addr = rsp_ch.write_addr;
         got.payload_byte = rsp_ch.payload_byte;
         got.packet_start = rsp_ch.packet_start;
         got.packet_length = rsp_ch.packet_length;
         got.header_id = rsp_ch.header_id;
         got.slot = rsp_ch.slot;
         got.last = rsp_ch.last;
         sb.check_result(got);
      end
   end

   // Offers one byte and waits for its transaction. The sender works in
   // bursts; valid is only lowered at the start of a gap, never right before
   // it is raised again.
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_byte(b);
      burst_left--;
      items_sent++;
   endtask

   // Pauses the sender until every owed result has come, then lets the
   // block finish any byte that produced no result.
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // Writes the whole register map, plus one index past its end that the
   // block must ignore.
   task automatic apply_config(input cfg_type c);
      write_register(REG_HEADER_A, c.header_a);
      write_register(REG_HEADER_B, c.header_b);
      write_register(REG_HEADER_C, c.header_c);
      write_register(REG_HEADER_D, c.header_d);
      write_register(REG_TAIL, c.tail);
      write_register(REG_MAX_LEN, c.max_len);
      write_register(REG_MAX_LEN + 3'd1 + 3'($urandom_range(0, 1)), 8'($urandom));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_list(input logic [7:0] bytes[]);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   function automatic logic [7:0] header_byte_of(int hid);
      case (hid)
         1: return sb.cfg.header_a;
         2: return sb.cfg.header_b;
         3: return sb.cfg.header_c;
         default: return sb.cfg.header_d;
      endcase
   endfunction

   // Payload is mostly random but now and then carries a tail or header byte.
   function automatic logic [7:0] payload_pick();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return sb.cfg.tail;
      if (k == 1) return header_byte_of($urandom_range(1, 4));
      return 8'($urandom);
   endfunction

   task automatic send_packet();
      logic [7:0] hb;
      int         n;
      int         ending;
      hb = header_byte_of($urandom_range(1, 4));
      n = $urandom_range(0, 12);
      ending = $urandom_range(0, 9);
      send_byte(hb);
      send_byte(hb);
      repeat (n) send_byte(payload_pick());
      if (ending < 7) begin
         send_byte(sb.cfg.tail);
         send_byte(sb.cfg.tail);
      end else if (ending == 7) begin
         send_byte(sb.cfg.tail);
         send_byte(8'($urandom));
      end
   endtask

   // Noise: stray bytes, or a header byte with a broken second byte.
   task automatic send_noise();
      if ($urandom_range(0, 1) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
         send_byte(header_byte_of($urandom_range(1, 4)));
         send_byte(8'($urandom));
      end
   endtask

   function automatic cfg_type random_config(int phase_no);
      cfg_type c;
      c.header_a = 8'($urandom);
      c.header_b = 8'($urandom);
      c.header_c = 8'($urandom);
      c.header_d = 8'($urandom);
      c.tail = 8'($urandom);
      if ($urandom_range(0, 3) == 0) c.header_b = c.header_a;
      if ($urandom_range(0, 3) == 0) c.tail = c.header_c;
      case (phase_no)
         0: c.max_len = 8'd1;
         1: c.max_len = 8'd255;
         2: c.max_len = 8'($urandom_range(2, 6));
         3: c.max_len = 8'($urandom_range(7, 30));
         default: c.max_len = 8'($urandom_range(1, 255));
      endcase
      return c;
   endfunction

   initial begin
      cfg_type c;
      int      sent;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      burst_left = 0;
      hold_requests = 0;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values. A header id 1 packet with extreme payload and
      // a tail byte followed by data; a stray first byte; a mismatched second
      // byte; empty packets for header ids 2 and 3; a packet for header id 4.
      send_list('{8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hDD, 8'h01, 8'hDD, 8'hDD,
                  8'h12, 8'h34, 8'hFF, 8'hEE,
                  8'hEE, 8'hEE, 8'hDD, 8'hDD,
                  8'hFD, 8'hFD, 8'hDD, 8'hDD,
                  8'hCC, 8'hCC, 8'hA5, 8'hDD, 8'hDD});
      settle();

      // Duplicate header registers, a tail equal to a header and a short
      // maximum: overflow on a data byte, on a tail plus data pair, and on
      // the held tail byte where the next byte restarts the header search.
      c.header_a = 8'h00;
      c.header_b = 8'h00;
      c.header_c = 8'h3C;
      c.header_d = 8'h81;
      c.tail = 8'h3C;
      c.max_len = 8'd3;
      apply_config(c);
      send_list('{8'h00, 8'h00, 8'h01, 8'h02, 8'h03,
                  8'h3C, 8'h3C, 8'h11, 8'h3C, 8'h22,
                  8'h81, 8'h81, 8'h44, 8'h55, 8'h3C, 8'h00, 8'h00, 8'h3C, 8'h3C});
      settle();

      // A zero maximum closes the packet after every stored byte.
      c.header_a = 8'hFF;
      c.header_b = 8'h01;
      c.header_c = 8'h80;
      c.header_d = 8'h7F;
      c.tail = 8'hFE;
      c.max_len = 8'd0;
      apply_config(c);
      send_list('{8'hFF, 8'hFF, 8'h10, 8'h7F, 8'h7F, 8'hFE, 8'h20, 8'h20});
      settle();

      // Random phases, each with its own register setting. Most traffic is
      // well-formed packets with random content, the rest is noise.
      for (int p = 0; p < PHASES; p++) begin
         apply_config(random_config(p));
         if (p == 1) hold_requests++;
         sent = items_sent;
         while (items_sent - sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
               send_packet();
            end else begin
               send_noise();
            end
         end
         settle();
      end

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("dual_byte_header_packet_deframer_tb: clean");
      end else begin
         $display("dual_byte_header_packet_deframer_tb: errors");
      end
      $finish;
   end

endmodule
